// ===== rtl/mccn_pkg.sv =====
// Package for the mean colour name classifier: field widths, colour codes,
// scaled thresholds, register indexes and the configuration struct.
// Used by mccn_classify and mean_color_name_classifier_core.
package mccn_pkg;

  localparam int FRAC_BITS = 4;
  localparam int CH_W      = 12;
  localparam int SUM_W     = 14;
  localparam int MUL_W     = 17;
  localparam int DIST_W    = 15;
  localparam int CLASS_W   = 4;
  localparam int IDX_W     = 2;

  typedef enum logic [CLASS_W-1:0] {
    COL_WHITE   = 4'd0,
    COL_BLACK   = 4'd1,
    COL_GRAY    = 4'd2,
    COL_ORANGE  = 4'd3,
    COL_YELLOW  = 4'd4,
    COL_RED     = 4'd5,
    COL_PURPLE  = 4'd6,
    COL_YGREEN  = 4'd7,
    COL_GREEN   = 4'd8,
    COL_BLUE    = 4'd9,
    COL_PINK    = 4'd10,
    COL_BROWN   = 4'd11
  } color_t;

  localparam logic [IDX_W-1:0] REG_GRAY_SPREAD = 2'd0;
  localparam logic [IDX_W-1:0] REG_WHITE_LEVEL = 2'd1;
  localparam logic [IDX_W-1:0] REG_BLACK_LEVEL = 2'd2;

  localparam logic [CH_W-1:0] RST_GRAY_SPREAD = 12'd480;
  localparam logic [CH_W-1:0] RST_WHITE_LEVEL = 12'd3200;
  localparam logic [CH_W-1:0] RST_BLACK_LEVEL = 12'd800;

  // Integer thresholds scaled to the channel fixed point.
  localparam logic [CH_W-1:0] T80  = CH_W'(80  << FRAC_BITS);
  localparam logic [CH_W-1:0] T100 = CH_W'(100 << FRAC_BITS);
  localparam logic [CH_W-1:0] T120 = CH_W'(120 << FRAC_BITS);
  localparam logic [CH_W-1:0] T150 = CH_W'(150 << FRAC_BITS);
  localparam logic [CH_W-1:0] T180 = CH_W'(180 << FRAC_BITS);
  localparam logic [CH_W-1:0] T200 = CH_W'(200 << FRAC_BITS);
  localparam logic [CH_W-1:0] FULL = CH_W'(255 << FRAC_BITS);

  typedef struct packed {
    logic [CH_W-1:0] gray_spread_limit;
    logic [CH_W-1:0] white_level;
    logic [CH_W-1:0] black_level;
  } cfg_t;

endpackage

// ===== rtl/mccn_classify.sv =====
// Combinational colour naming of one blue, green, red triple.
// Depends on mccn_pkg for widths, thresholds, colour codes and cfg_t.
module mccn_classify (
  input  logic [mccn_pkg::CH_W-1:0] blue_mean,
  input  logic [mccn_pkg::CH_W-1:0] green_mean,
  input  logic [mccn_pkg::CH_W-1:0] red_mean,
  input  mccn_pkg::cfg_t            cfg,
  output mccn_pkg::color_t          color_class
);

  logic [mccn_pkg::CH_W-1:0]   b, g, r, mx, mn, spread;
  logic [mccn_pkg::SUM_W-1:0]  s, white3, black3;
  logic [mccn_pkg::MUL_W-1:0]  r10, g10, b10, s6, s4, s3;
  logic [mccn_pkg::CH_W-1:0]   adr, adg, adb;
  logic [mccn_pkg::DIST_W-1:0] dr, dg, db;

  assign b = blue_mean;
  assign g = green_mean;
  assign r = red_mean;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  assign spread = mx - mn;
  assign s      = mccn_pkg::SUM_W'(r) + mccn_pkg::SUM_W'(g) + mccn_pkg::SUM_W'(b);
  assign white3 = mccn_pkg::SUM_W'(cfg.white_level) * mccn_pkg::SUM_W'(3);
  assign black3 = mccn_pkg::SUM_W'(cfg.black_level) * mccn_pkg::SUM_W'(3);

  // Ratio tests are cross-multiplied with small constants.
  assign r10 = mccn_pkg::MUL_W'(r) * mccn_pkg::MUL_W'(10);
  assign g10 = mccn_pkg::MUL_W'(g) * mccn_pkg::MUL_W'(10);
  assign b10 = mccn_pkg::MUL_W'(b) * mccn_pkg::MUL_W'(10);
  assign s6  = mccn_pkg::MUL_W'(s) * mccn_pkg::MUL_W'(6);
  assign s4  = mccn_pkg::MUL_W'(s) * mccn_pkg::MUL_W'(4);
  assign s3  = mccn_pkg::MUL_W'(s) * mccn_pkg::MUL_W'(3);

  // L1 distance to the full-scale primaries.
  assign adr = (r > mccn_pkg::FULL) ? r - mccn_pkg::FULL : mccn_pkg::FULL - r;
  assign adg = (g > mccn_pkg::FULL) ? g - mccn_pkg::FULL : mccn_pkg::FULL - g;
  assign adb = (b > mccn_pkg::FULL) ? b - mccn_pkg::FULL : mccn_pkg::FULL - b;
  assign dr  = mccn_pkg::DIST_W'(adr) + mccn_pkg::DIST_W'(g) + mccn_pkg::DIST_W'(b);
  assign dg  = mccn_pkg::DIST_W'(r) + mccn_pkg::DIST_W'(adg) + mccn_pkg::DIST_W'(b);
  assign db  = mccn_pkg::DIST_W'(r) + mccn_pkg::DIST_W'(g) + mccn_pkg::DIST_W'(adb);

  always_comb begin
    if (spread < cfg.gray_spread_limit) begin
      if (s > white3)      color_class = mccn_pkg::COL_WHITE;
      else if (s < black3) color_class = mccn_pkg::COL_BLACK;
      else                 color_class = mccn_pkg::COL_GRAY;
    end else if (r > g && r > b) begin
      if (g > mccn_pkg::T150 && r > mccn_pkg::T200 && b < mccn_pkg::T100)
        color_class = mccn_pkg::COL_ORANGE;
      else if (g > mccn_pkg::T180 && r > mccn_pkg::T200 && b < mccn_pkg::T120)
        color_class = mccn_pkg::COL_YELLOW;
      else if (r10 > s6 && g10 < s3)
        color_class = mccn_pkg::COL_RED;
      else if (r10 > s4 && b10 > s3)
        color_class = mccn_pkg::COL_PURPLE;
      else
        color_class = mccn_pkg::COL_RED;
    end else if (g > r && g > b) begin
      if (r > mccn_pkg::T150 && g > mccn_pkg::T180 && b < mccn_pkg::T100)
        color_class = mccn_pkg::COL_YGREEN;
      else
        color_class = mccn_pkg::COL_GREEN;
    end else if (b > r && b > g) begin
      if (r > mccn_pkg::T150 && b > mccn_pkg::T150 && g < mccn_pkg::T120)
        color_class = mccn_pkg::COL_PURPLE;
      else
        color_class = mccn_pkg::COL_BLUE;
    end else begin
      // No strictly dominant channel: fixed tests, then nearest primary.
      if (r > mccn_pkg::T150 && g > mccn_pkg::T150 && b < mccn_pkg::T100)
        color_class = mccn_pkg::COL_YELLOW;
      else if (r > mccn_pkg::T150 && b > mccn_pkg::T150 && g < mccn_pkg::T120)
        color_class = mccn_pkg::COL_PURPLE;
      else if (r > mccn_pkg::T180 && g > mccn_pkg::T100 && b > mccn_pkg::T180)
        color_class = mccn_pkg::COL_PINK;
      else if (r > mccn_pkg::T120 && g > mccn_pkg::T80 && b < mccn_pkg::T80)
        color_class = mccn_pkg::COL_BROWN;
      else if (dr <= dg && dr <= db)
        color_class = mccn_pkg::COL_RED;
      else if (dg <= db)
        color_class = mccn_pkg::COL_GREEN;
      else
        color_class = mccn_pkg::COL_BLUE;
    end
  end

endmodule

// ===== rtl/mean_color_name_classifier_core.sv =====
// Top level of the mean colour name classifier: input register, classifier
// logic, result register and the configuration registers.
// Depends on mccn_pkg and mccn_classify.
//
//  channel | direction | word
//  s_*     | in        | tdata[11:0] blue_mean, [23:12] green_mean, [35:24] red_mean
//  m_*     | out       | tdata[3:0] color_class
//  cfg_*   | in        | cfg_index selects register, cfg_data is the value
//
// Two register stages: a word is captured in the input register, classified,
// and captured in the result register; one word is taken per cycle while
// m_tready does not stall the result. Both stages move together under
// m_tready; a stalled result holds a full input stage too.
// rst is synchronous and clears the valid flags and loads register defaults.
module mean_color_name_classifier_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,   // blue_mean, green_mean, red_mean
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // color_class
  input  logic                       cfg_we,
  input  logic [mccn_pkg::IDX_W-1:0] cfg_index,
  input  logic [mccn_pkg::CH_W-1:0]  cfg_data
);

  mccn_pkg::cfg_t            cfg;
  logic                      in_valid;
  logic [mccn_pkg::CH_W-1:0] blue, green, red;
  mccn_pkg::color_t          color_next;
  mccn_pkg::color_t          color;
  logic                      advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gray_spread_limit <= mccn_pkg::RST_GRAY_SPREAD;
      cfg.white_level       <= mccn_pkg::RST_WHITE_LEVEL;
      cfg.black_level       <= mccn_pkg::RST_BLACK_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        mccn_pkg::REG_GRAY_SPREAD: cfg.gray_spread_limit <= cfg_data;
        mccn_pkg::REG_WHITE_LEVEL: cfg.white_level       <= cfg_data;
        mccn_pkg::REG_BLACK_LEVEL: cfg.black_level       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input stage empties when the result register can take its word.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      blue  <= s_tdata[11:0];
      green <= s_tdata[23:12];
      red   <= s_tdata[35:24];
    end
  end

  mccn_classify u_classify (
    .blue_mean   (blue),
    .green_mean  (green),
    .red_mean    (red),
    .cfg         (cfg),
    .color_class (color_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color <= color_next;
    end
  end

  assign m_tdata = {4'b0000, color};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are full and stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !in_valid) |=> !m_tvalid)
    else $error("result word repeated after it was taken");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("classified word lost between stages");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] == 4'b0000))
    else $error("result padding bits not zero");

endmodule
